// ===== rtl/core/mhlp_pkg.sv =====
// Shared constants, types and command/status structs of the mail header line parser.
`default_nettype none
package mhlp_pkg;

  // Default depth of the interior whitespace gap store
  localparam int unsigned GAP_DEPTH_DEF = 16;

  // Special byte values
  localparam logic [7:0] BYTE_NL    = 8'd10;
  localparam logic [7:0] BYTE_NUL   = 8'd0;
  localparam logic [7:0] BYTE_COLON = 8'd58;
  localparam logic [7:0] BYTE_SPACE = 8'd32;

  // Result kinds
  localparam logic [1:0] KIND_NAME = 2'd0;
  localparam logic [1:0] KIND_BODY = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Line end status codes
  localparam logic [1:0] STAT_NEW    = 2'd0;
  localparam logic [1:0] STAT_MORE   = 2'd1;
  localparam logic [1:0] STAT_EOH    = 2'd2;
  localparam logic [1:0] STAT_NONAME = 2'd3;

  // Source of the byte loaded into the result register
  typedef enum logic [2:0] {
    SRC_INPUT,
    SRC_SPACE,
    SRC_CHAR,
    SRC_GAP,
    SRC_ZERO
  } src_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load_out;    // load the result register
    src_e       out_src;
    logic [1:0] out_kind;
    logic [1:0] out_status;
    logic       out_last;
    logic       char_capture; // hold the input byte for later
    logic       gap_push;     // buffer a whitespace byte or flag overflow
    logic       flush_start;  // read gap entry zero
    logic       flush_next;   // read the following gap entry
    logic       gap_reset;    // empty the gap store
    logic       line_clear;   // empty gap store and clear overflow flag
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_ws;
    logic is_eol;
    logic is_colon;
    logic gap_empty;
    logic flush_last;
    logic out_free;
  } sts_t;

  // Whitespace: tab through carriage return, and space
  function automatic logic is_ws(input logic [7:0] c);
    return (c == BYTE_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mail_header_line_parser.sv =====
// Top level of the mail header line parser: controller plus datapath.
// Takes one header text byte per request and emits name bytes, contents bytes and one
// line end status per line. A name byte after a folded whitespace run comes after a
// single space, and a contents byte after the interior whitespace bytes it releases,
// as the gap store has one registered read port that is drained one entry per cycle,
// while the output is not stalled, through the single result register. Whitespace beyond
// GAP_DEPTH bytes in one interior run is dropped and flagged on the line end result.
`default_nettype none
module mail_header_line_parser #(
  parameter int unsigned GAP_DEPTH = mhlp_pkg::GAP_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] text_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      item_kind_o,
  output logic [7:0]      byte_value_o,
  output logic [1:0]      line_status_o,
  output logic            gap_overflow_o,
  output logic            last_of_run_o
);

  mhlp_pkg::cmd_t cmd;
  mhlp_pkg::sts_t sts;

  mhlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mhlp_datapath #(
    .GAP_DEPTH (GAP_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .text_byte_i    (text_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .item_kind_o    (item_kind_o),
    .byte_value_o   (byte_value_o),
    .line_status_o  (line_status_o),
    .gap_overflow_o (gap_overflow_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/mhlp_datapath.sv =====
// Datapath: byte classification, gap store, held byte and result register.
`default_nettype none
module mhlp_datapath #(
  parameter int unsigned GAP_DEPTH = mhlp_pkg::GAP_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    text_byte_i,
  input  wire mhlp_pkg::cmd_t cmd_i,
  output mhlp_pkg::sts_t     sts_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [1:0]         item_kind_o,
  output logic [7:0]         byte_value_o,
  output logic [1:0]         line_status_o,
  output logic               gap_overflow_o,
  output logic               last_of_run_o
);

  localparam int unsigned CW = $clog2(GAP_DEPTH + 1);
  localparam int unsigned GW = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;

  logic [7:0]    gap_mem [GAP_DEPTH];
  logic [CW-1:0] gap_cnt_q;
  logic [GW-1:0] rd_idx_q;
  logic [7:0]    rd_data_q;
  logic [7:0]    char_q;
  logic          ovf_q;
  logic          gap_full;
  logic [GW-1:0] idx_nxt;
  logic [7:0]    out_byte;

  logic          out_valid_q;
  logic [1:0]    kind_q;
  logic [7:0]    byte_q;
  logic [1:0]    status_q;
  logic          ovf_out_q;
  logic          last_q;

  assign gap_full = (gap_cnt_q == CW'(GAP_DEPTH));
  assign idx_nxt  = rd_idx_q + GW'(1);

  // Report classification and progress
  always_comb begin
    sts_o.is_ws      = mhlp_pkg::is_ws(text_byte_i);
    sts_o.is_eol     = (text_byte_i == mhlp_pkg::BYTE_NL) || (text_byte_i == mhlp_pkg::BYTE_NUL);
    sts_o.is_colon   = (text_byte_i == mhlp_pkg::BYTE_COLON);
    sts_o.gap_empty  = (gap_cnt_q == '0);
    sts_o.flush_last = ((CW'(rd_idx_q) + CW'(1)) == gap_cnt_q);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Write and read the gap store
  always_ff @(posedge clk_i) begin
    if (cmd_i.gap_push && !gap_full) begin
      gap_mem[gap_cnt_q[GW-1:0]] <= text_byte_i;
    end
    if (cmd_i.flush_start) begin
      rd_data_q <= gap_mem[0];
    end else if (cmd_i.flush_next) begin
      rd_data_q <= gap_mem[idx_nxt];
    end
  end

  // Track fill count, read index and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_cnt_q <= '0;
      rd_idx_q  <= '0;
      ovf_q     <= 1'b0;
    end else begin
      if (cmd_i.line_clear || cmd_i.gap_reset) begin
        gap_cnt_q <= '0;
      end else if (cmd_i.gap_push && !gap_full) begin
        gap_cnt_q <= gap_cnt_q + CW'(1);
      end
      if (cmd_i.line_clear) begin
        ovf_q <= 1'b0;
      end else if (cmd_i.gap_push && gap_full) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.flush_start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.flush_next) begin
        rd_idx_q <= idx_nxt;
      end
    end
  end

  // Hold the byte that follows a folded space or a gap flush
  always_ff @(posedge clk_i) begin
    if (cmd_i.char_capture) begin
      char_q <= text_byte_i;
    end
  end

  // Pick the result byte
  always_comb begin
    case (cmd_i.out_src)
      mhlp_pkg::SRC_INPUT: out_byte = text_byte_i;
      mhlp_pkg::SRC_SPACE: out_byte = mhlp_pkg::BYTE_SPACE;
      mhlp_pkg::SRC_CHAR:  out_byte = char_q;
      mhlp_pkg::SRC_GAP:   out_byte = rd_data_q;
      default:             out_byte = 8'd0;
    endcase
  end

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      kind_q    <= cmd_i.out_kind;
      byte_q    <= out_byte;
      status_q  <= cmd_i.out_status;
      ovf_out_q <= (cmd_i.out_kind == mhlp_pkg::KIND_END) ? ovf_q : 1'b0;
      last_q    <= cmd_i.out_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign item_kind_o    = kind_q;
  assign byte_value_o   = byte_q;
  assign line_status_o  = status_q;
  assign gap_overflow_o = ovf_out_q;
  assign last_of_run_o  = last_q;

endmodule
`default_nettype wire

// ===== rtl/core/mhlp_ctrl.sv =====
// Controller: line phase state machine and result sequencing.
`default_nettype none
module mhlp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire mhlp_pkg::sts_t sts_i,
  output mhlp_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] ST_START     = 3'd0;
  localparam logic [2:0] ST_NAME      = 3'd1;
  localparam logic [2:0] ST_SKIP      = 3'd2;
  localparam logic [2:0] ST_BODY      = 3'd3;
  localparam logic [2:0] ST_NAME_CHAR = 3'd4;
  localparam logic [2:0] ST_FLUSH     = 3'd5;
  localparam logic [2:0] ST_BODY_CHAR = 3'd6;

  logic [2:0] state_q, state_d;
  logic       cont_q, cont_d;
  logic       pend_q, pend_d;
  logic       idle;
  logic       accept;

  assign idle       = (state_q == ST_START) || (state_q == ST_NAME) ||
                      (state_q == ST_SKIP)  || (state_q == ST_BODY);
  assign in_stall_o = !(idle && sts_i.out_free);
  assign accept     = in_valid_i && idle && sts_i.out_free;

  // Decide the next phase and datapath commands
  always_comb begin
    state_d = state_q;
    cont_d  = cont_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    cmd_o.out_src    = mhlp_pkg::SRC_INPUT;
    cmd_o.out_kind   = mhlp_pkg::KIND_NAME;
    cmd_o.out_status = mhlp_pkg::STAT_NEW;
    case (state_q)
      ST_START: begin
        if (accept) begin
          if (sts_i.is_eol) begin
            cmd_o.load_out   = 1'b1;
            cmd_o.out_src    = mhlp_pkg::SRC_ZERO;
            cmd_o.out_kind   = mhlp_pkg::KIND_END;
            cmd_o.out_status = mhlp_pkg::STAT_EOH;
            cmd_o.out_last   = 1'b1;
            cmd_o.line_clear = 1'b1;
            cont_d  = 1'b0;
            pend_d  = 1'b0;
          end else if (sts_i.is_ws) begin
            cont_d  = 1'b1;
            state_d = ST_SKIP;
          end else if (sts_i.is_colon) begin
            state_d = ST_SKIP;
          end else begin
            cmd_o.load_out = 1'b1;
            cmd_o.out_last = 1'b1;
            state_d = ST_NAME;
          end
        end
      end
      ST_NAME: begin
        if (accept) begin
          if (sts_i.is_eol) begin
            cmd_o.load_out   = 1'b1;
            cmd_o.out_src    = mhlp_pkg::SRC_ZERO;
            cmd_o.out_kind   = mhlp_pkg::KIND_END;
            cmd_o.out_status = mhlp_pkg::STAT_NONAME;
            cmd_o.out_last   = 1'b1;
            cmd_o.line_clear = 1'b1;
            cont_d  = 1'b0;
            pend_d  = 1'b0;
            state_d = ST_START;
          end else if (sts_i.is_colon) begin
            pend_d  = 1'b0;
            state_d = ST_SKIP;
          end else if (sts_i.is_ws) begin
            pend_d = 1'b1;
          end else if (pend_q) begin
            // Emit the folded space now, the byte from ST_NAME_CHAR once the output is free
            cmd_o.load_out     = 1'b1;
            cmd_o.out_src      = mhlp_pkg::SRC_SPACE;
            cmd_o.char_capture = 1'b1;
            pend_d  = 1'b0;
            state_d = ST_NAME_CHAR;
          end else begin
            cmd_o.load_out = 1'b1;
            cmd_o.out_last = 1'b1;
          end
        end
      end
      ST_SKIP: begin
        if (accept) begin
          if (sts_i.is_eol) begin
            cmd_o.load_out   = 1'b1;
            cmd_o.out_src    = mhlp_pkg::SRC_ZERO;
            cmd_o.out_kind   = mhlp_pkg::KIND_END;
            cmd_o.out_status = cont_q ? mhlp_pkg::STAT_EOH : mhlp_pkg::STAT_NEW;
            cmd_o.out_last   = 1'b1;
            cmd_o.line_clear = 1'b1;
            cont_d  = 1'b0;
            pend_d  = 1'b0;
            state_d = ST_START;
          end else if (!sts_i.is_ws) begin
            cmd_o.load_out = 1'b1;
            cmd_o.out_kind = mhlp_pkg::KIND_BODY;
            cmd_o.out_last = 1'b1;
            state_d = ST_BODY;
          end
        end
      end
      ST_BODY: begin
        if (accept) begin
          if (sts_i.is_eol) begin
            cmd_o.load_out   = 1'b1;
            cmd_o.out_src    = mhlp_pkg::SRC_ZERO;
            cmd_o.out_kind   = mhlp_pkg::KIND_END;
            cmd_o.out_status = cont_q ? mhlp_pkg::STAT_MORE : mhlp_pkg::STAT_NEW;
            cmd_o.out_last   = 1'b1;
            cmd_o.line_clear = 1'b1;
            cont_d  = 1'b0;
            pend_d  = 1'b0;
            state_d = ST_START;
          end else if (sts_i.is_ws) begin
            cmd_o.gap_push = 1'b1;
          end else if (sts_i.gap_empty) begin
            cmd_o.load_out = 1'b1;
            cmd_o.out_kind = mhlp_pkg::KIND_BODY;
            cmd_o.out_last = 1'b1;
          end else begin
            // Release the held whitespace ahead of this byte
            cmd_o.char_capture = 1'b1;
            cmd_o.flush_start  = 1'b1;
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_src  = mhlp_pkg::SRC_GAP;
          cmd_o.out_kind = mhlp_pkg::KIND_BODY;
          if (sts_i.flush_last) begin
            cmd_o.gap_reset = 1'b1;
            state_d = ST_BODY_CHAR;
          end else begin
            cmd_o.flush_next = 1'b1;
          end
        end
      end
      ST_NAME_CHAR: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_src  = mhlp_pkg::SRC_CHAR;
          cmd_o.out_last = 1'b1;
          state_d = ST_NAME;
        end
      end
      ST_BODY_CHAR: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_src  = mhlp_pkg::SRC_CHAR;
          cmd_o.out_kind = mhlp_pkg::KIND_BODY;
          cmd_o.out_last = 1'b1;
          state_d = ST_BODY;
        end
      end
      default: begin
        state_d = ST_START;
      end
    endcase
  end

  // Advance the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
      cont_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cont_q  <= cont_d;
      pend_q  <= pend_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mhlp_checker.sv =====
// Port level checker for the mail header line parser, bound to the top level.
`default_nettype none
module mhlp_port_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] text_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] item_kind_o,
  input wire logic [7:0] byte_value_o,
  input wire logic [1:0] line_status_o,
  input wire logic       gap_overflow_o,
  input wire logic       last_of_run_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(item_kind_o) &&
    $stable(byte_value_o) && $stable(line_status_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // Line end carries a zero byte and closes its run
  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (item_kind_o == mhlp_pkg::KIND_END) |-> (byte_value_o == 8'd0) &&
    last_of_run_o)
    else $error("malformed line end");

  // Byte results carry no status
  a_byte_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (item_kind_o != mhlp_pkg::KIND_END) |-> (line_status_o == 2'd0) &&
    !gap_overflow_o && (item_kind_o != 2'd3))
    else $error("byte result with status");

  // Take no request while a result waits
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request taken while result stalled");

  // An accepted byte in 14..127, not space or colon, yields a result, even via a gap flush
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !text_byte_i[7] && (text_byte_i != 8'd32) &&
    (text_byte_i > 8'd13) && (text_byte_i != 8'd58) |=> ##[0:1] out_valid_o)
    else $error("printable byte gave no result");

endmodule

bind mail_header_line_parser mhlp_port_checker u_mhlp_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .text_byte_i    (text_byte_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .item_kind_o    (item_kind_o),
  .byte_value_o   (byte_value_o),
  .line_status_o  (line_status_o),
  .gap_overflow_o (gap_overflow_o),
  .last_of_run_o  (last_of_run_o)
);
`default_nettype wire
